>>> design/gpsm_pkg.sv
// Shared types and constants for the gamepad poll serial master.
package gpsm_pkg;

    localparam int TICK_COUNT_WIDTH = 16;
    localparam int CFG_WIDTH        = 16;
    localparam int BUTTON_WIDTH     = 16;
    localparam int BYTE_WIDTH       = 8;
    localparam int APB_ADDR_WIDTH   = 5;
    localparam int APB_DATA_WIDTH   = 32;

    localparam logic [2:0] REG_BIT_HIGH     = 3'd0;
    localparam logic [2:0] REG_BIT_LOW      = 3'd1;
    localparam logic [2:0] REG_SELECT_SETUP = 3'd2;
    localparam logic [2:0] REG_ACK_PULSE    = 3'd3;
    localparam logic [2:0] REG_ACK_TIMEOUT  = 3'd4;

    localparam logic [CFG_WIDTH-1:0] RST_BIT_HIGH     = 16'd10;
    localparam logic [CFG_WIDTH-1:0] RST_BIT_LOW      = 16'd15;
    localparam logic [CFG_WIDTH-1:0] RST_SELECT_SETUP = 16'd10;
    localparam logic [CFG_WIDTH-1:0] RST_ACK_PULSE    = 16'd5;
    localparam logic [CFG_WIDTH-1:0] RST_ACK_TIMEOUT  = 16'd100;

    localparam logic [BYTE_WIDTH-1:0] CMD_START = 8'h01;
    localparam logic [BYTE_WIDTH-1:0] CMD_POLL  = 8'h42;
    localparam logic [BYTE_WIDTH-1:0] CMD_IDLE  = 8'h00;

    localparam logic [2:0] LAST_ACKED_BYTE = 3'd3;
    localparam logic [2:0] LAST_BYTE       = 3'd4;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_ACK = 1'b1;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] bit_high_ticks;
        logic [CFG_WIDTH-1:0] bit_low_ticks;
        logic [CFG_WIDTH-1:0] select_setup_ticks;
        logic [CFG_WIDTH-1:0] ack_pulse_ticks;
        logic [CFG_WIDTH-1:0] ack_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic                    clock_line;
        logic                    command_line;
        logic                    select_line;
        logic                    done_res;
        logic                    status;
        logic [BUTTON_WIDTH-1:0] buttons;
        logic                    busy_res;
    } t_result;

endpackage

>>> design/gpsm_cfg_regs.sv
// Configuration register file with its APB-style access port.
module gpsm_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gpsm_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [gpsm_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [gpsm_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    output gpsm_pkg::t_cfg                       o_cfg
);
    import gpsm_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [2:0]           reg_idx;
    logic [CFG_WIDTH-1:0] wr_val;
    logic [CFG_WIDTH-1:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];
    assign wr_val  = pwdata[CFG_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_high_ticks     <= RST_BIT_HIGH;
            r_cfg.bit_low_ticks      <= RST_BIT_LOW;
            r_cfg.select_setup_ticks <= RST_SELECT_SETUP;
            r_cfg.ack_pulse_ticks    <= RST_ACK_PULSE;
            r_cfg.ack_timeout_ticks  <= RST_ACK_TIMEOUT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BIT_HIGH:     r_cfg.bit_high_ticks     <= wr_val;
                REG_BIT_LOW:      r_cfg.bit_low_ticks      <= wr_val;
                REG_SELECT_SETUP: r_cfg.select_setup_ticks <= wr_val;
                REG_ACK_PULSE:    r_cfg.ack_pulse_ticks    <= wr_val;
                REG_ACK_TIMEOUT:  r_cfg.ack_timeout_ticks  <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BIT_HIGH:     rd_val = r_cfg.bit_high_ticks;
            REG_BIT_LOW:      rd_val = r_cfg.bit_low_ticks;
            REG_SELECT_SETUP: rd_val = r_cfg.select_setup_ticks;
            REG_ACK_PULSE:    rd_val = r_cfg.ack_pulse_ticks;
            REG_ACK_TIMEOUT:  rd_val = r_cfg.ack_timeout_ticks;
            default:          rd_val = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_WIDTH-CFG_WIDTH){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

>>> design/gpsm_core.sv
// Poll sequencer: advances one tick per accepted item and forms its pin levels.
module gpsm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_start_req,
    input  logic              i_data_line,
    input  logic              i_ack_line,
    input  gpsm_pkg::t_cfg    i_cfg,
    output gpsm_pkg::t_result o_result
);
    import gpsm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SETUP    = 4'd1,
        PH_BIT_HIGH = 4'd2,
        PH_BIT_LOW  = 4'd3,
        PH_ACK_HIGH = 4'd4,
        PH_ACK_WAIT = 4'd5,
        PH_HOLD     = 4'd6
    } t_phase;

    localparam logic [TICK_COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int CMP_WIDTH = (TICK_COUNT_WIDTH > CFG_WIDTH) ? TICK_COUNT_WIDTH : CFG_WIDTH;

    t_phase                        r_phase, n_phase;
    logic [2:0]                    r_byte_idx, n_byte_idx;
    logic [2:0]                    r_bit_idx, n_bit_idx;
    logic [TICK_COUNT_WIDTH-1:0]   r_tick_cnt, n_tick_cnt;
    logic [BYTE_WIDTH-1:0]         r_tx_shift, n_tx_shift;
    logic [BYTE_WIDTH-1:0]         r_rx_shift, n_rx_shift;
    logic [BYTE_WIDTH-1:0]         r_held_high, n_held_high;
    logic [BUTTON_WIDTH-1:0]       r_last_buttons, n_last_buttons;

    logic [CFG_WIDTH-1:0]          limit;
    logic [TICK_COUNT_WIDTH-1:0]   tick_inc;
    logic                          time_up;
    logic [BYTE_WIDTH-1:0]         rx_new;
    logic [2:0]                    bit_inc;
    logic [2:0]                    byte_inc;
    logic                          done;
    logic                          stat;

    always_comb begin
        case (r_phase)
            PH_SETUP, PH_HOLD: limit = i_cfg.select_setup_ticks;
            PH_BIT_HIGH:       limit = i_cfg.bit_high_ticks;
            PH_BIT_LOW:        limit = i_cfg.bit_low_ticks;
            PH_ACK_HIGH:       limit = i_cfg.ack_pulse_ticks;
            PH_ACK_WAIT:       limit = i_cfg.ack_timeout_ticks;
            default:           limit = i_cfg.bit_high_ticks;
        endcase
    end

    assign tick_inc = (r_tick_cnt != COUNT_MAX) ? r_tick_cnt + 1'b1 : r_tick_cnt;
    assign time_up  = (CMP_WIDTH'(tick_inc) >= CMP_WIDTH'(limit)) || (tick_inc == COUNT_MAX);
    assign rx_new   = {i_data_line, r_rx_shift[BYTE_WIDTH-1:1]};
    assign bit_inc  = r_bit_idx + 3'd1;
    assign byte_inc = r_byte_idx + 3'd1;

    always_comb begin
        n_phase        = r_phase;
        n_byte_idx     = r_byte_idx;
        n_bit_idx      = r_bit_idx;
        n_tick_cnt     = r_tick_cnt;
        n_tx_shift     = r_tx_shift;
        n_rx_shift     = r_rx_shift;
        n_held_high    = r_held_high;
        n_last_buttons = r_last_buttons;
        done           = 1'b0;
        stat           = STATUS_OK;
        case (r_phase)
            PH_SETUP: begin
                n_tick_cnt = tick_inc;
                if (time_up) begin
                    n_byte_idx = '0;
                    n_bit_idx  = '0;
                    n_tx_shift = CMD_START;
                    n_phase    = PH_BIT_HIGH;
                    n_tick_cnt = '0;
                end
            end
            PH_BIT_HIGH: begin
                n_tick_cnt = tick_inc;
                if (time_up) begin
                    n_phase    = PH_BIT_LOW;
                    n_tick_cnt = '0;
                end
            end
            PH_BIT_LOW: begin
                n_tick_cnt = tick_inc;
                if (time_up) begin
                    n_rx_shift = rx_new;
                    n_tx_shift = {1'b0, r_tx_shift[BYTE_WIDTH-1:1]};
                    n_bit_idx  = bit_inc;
                    n_tick_cnt = '0;
                    if (bit_inc != 3'd0) begin
                        n_phase = PH_BIT_HIGH;
                    end else if (r_byte_idx >= LAST_BYTE) begin
                        n_phase = PH_HOLD;
                    end else begin
                        if (r_byte_idx == LAST_ACKED_BYTE) begin
                            n_held_high = rx_new;
                        end
                        n_phase = PH_ACK_HIGH;
                    end
                end
            end
            PH_ACK_HIGH: begin
                n_tick_cnt = tick_inc;
                if (time_up) begin
                    n_phase    = PH_ACK_WAIT;
                    n_tick_cnt = '0;
                end
            end
            PH_ACK_WAIT: begin
                if (!i_ack_line) begin
                    n_byte_idx = byte_inc;
                    n_bit_idx  = '0;
                    n_tx_shift = (byte_inc == 3'd1) ? CMD_POLL : CMD_IDLE;
                    n_phase    = PH_BIT_HIGH;
                    n_tick_cnt = '0;
                end else begin
                    n_tick_cnt = tick_inc;
                    if (time_up) begin
                        n_phase    = PH_IDLE;
                        n_tick_cnt = '0;
                        done       = 1'b1;
                        stat       = STATUS_NO_ACK;
                    end
                end
            end
            PH_HOLD: begin
                n_tick_cnt = tick_inc;
                if (time_up) begin
                    n_last_buttons = {r_held_high, r_rx_shift};
                    n_phase        = PH_IDLE;
                    n_tick_cnt     = '0;
                    done           = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_start_req) begin
                    n_byte_idx = '0;
                    n_bit_idx  = '0;
                    n_phase    = PH_SETUP;
                    n_tick_cnt = '0;
                end
            end
        endcase
    end

    always_comb begin
        o_result.clock_line   = 1'b1;
        o_result.command_line = 1'b1;
        o_result.select_line  = 1'b0;
        case (n_phase)
            PH_IDLE:     o_result.select_line = 1'b1;
            PH_BIT_HIGH: o_result.command_line = n_tx_shift[0];
            PH_BIT_LOW: begin
                o_result.clock_line   = 1'b0;
                o_result.command_line = n_tx_shift[0];
            end
            PH_ACK_WAIT: o_result.clock_line = 1'b0;
            default: ;
        endcase
        o_result.done_res = done;
        o_result.status   = stat;
        o_result.buttons  = n_last_buttons;
        o_result.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_byte_idx     <= '0;
            r_bit_idx      <= '0;
            r_tick_cnt     <= '0;
            r_tx_shift     <= '0;
            r_rx_shift     <= '0;
            r_held_high    <= '0;
            r_last_buttons <= '1;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_byte_idx     <= n_byte_idx;
            r_bit_idx      <= n_bit_idx;
            r_tick_cnt     <= n_tick_cnt;
            r_tx_shift     <= n_tx_shift;
            r_rx_shift     <= n_rx_shift;
            r_held_high    <= n_held_high;
            r_last_buttons <= n_last_buttons;
        end
    end

endmodule

>>> design/gpsm_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module gpsm_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gpsm_pkg::t_result i_result,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output gpsm_pkg::t_result o_result
);
    import gpsm_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop        = r_main_valid & i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_result   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main       <= i_result;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_result;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

endmodule

>>> design/gamepad_poll_serial_master.sv
// Top level of the gamepad poll serial master.
// Each input item is one time tick carrying the sampled data and acknowledge
// pins and a start request. Each item yields exactly one result item with the
// clock, command and select pin levels, done and status flags, the last good
// button word and a busy flag. A start request is taken only while idle.
// The result of an item is registered in the output buffer before it is presented.
// One item is accepted per cycle unless stalled; the sequencer state advances
// in one pass of logic between its state registers and the result register.
// A two-entry output buffer lets one more item be accepted while a result
// waits; the input stalls only when both entries are full.
// Reset returns the sequencer to idle, sets the button word to all ones,
// empties the output buffer and loads the default timing registers. The user
// is to write them over the APB-style port while idle; the block won't check.
module gamepad_poll_serial_master (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_start_req,
    input  logic                                i_data_line,
    input  logic                                i_ack_line,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_clock_line,
    output logic                                o_command_line,
    output logic                                o_select_line,
    output logic                                o_done_res,
    output logic                                o_status,
    output logic [gpsm_pkg::BUTTON_WIDTH-1:0]   o_buttons,
    output logic                                o_busy_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gpsm_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [gpsm_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [gpsm_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready
);
    import gpsm_pkg::*;

    t_cfg    cfg;
    t_result step_result;
    t_result out_result;
    logic    can_push;
    logic    step;

    assign o_in_ready = can_push;
    assign step       = i_in_valid & can_push;

    gpsm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gpsm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_start_req (i_start_req),
        .i_data_line (i_data_line),
        .i_ack_line  (i_ack_line),
        .i_cfg       (cfg),
        .o_result    (step_result)
    );

    gpsm_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step),
        .i_result   (step_result),
        .o_can_push (can_push),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_clock_line   = out_result.clock_line;
    assign o_command_line = out_result.command_line;
    assign o_select_line  = out_result.select_line;
    assign o_done_res     = out_result.done_res;
    assign o_status       = out_result.status;
    assign o_buttons      = out_result.buttons;
    assign o_busy_res     = out_result.busy_res;

endmodule
